/* rtl/core/gforce_event_window_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// assertion macros for the g-force event window table unit
// concurrent checks that vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef GFORCE_EVENT_WINDOW_TABLE_UNIT_ASSERT_SVH
`define GFORCE_EVENT_WINDOW_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define GEWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gewt assertion failed");
// condition must never be true outside reset
`define GEWT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gewt forbidden condition seen");
`else
`define GEWT_ASSERT(lbl, clk, rst_n, prop)
`define GEWT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/gewt_pkg.sv */
// ----------------------------------------------------------------------------
// gewt_pkg
// shared types, codes and the per-axis limit test
// ----------------------------------------------------------------------------
package gewt_pkg;

  // result action codes
  localparam logic [2:0] ActQuiet    = 3'd0;
  localparam logic [2:0] ActBadOrder = 3'd1;
  localparam logic [2:0] ActNew      = 3'd2;
  localparam logic [2:0] ActStartExt = 3'd3;
  localparam logic [2:0] ActCovered  = 3'd4;
  localparam logic [2:0] ActEndExt   = 3'd5;
  localparam logic [2:0] ActFull     = 3'd6;

  // configuration register indexes
  localparam logic [2:0] RegRefX     = 3'd0;
  localparam logic [2:0] RegRefY     = 3'd1;
  localparam logic [2:0] RegRefZ     = 3'd2;
  localparam logic [2:0] RegOrder    = 3'd3;
  localparam logic [2:0] RegFbLim    = 3'd4;
  localparam logic [2:0] RegLrLim    = 3'd5;
  localparam logic [2:0] RegUdLim    = 3'd6;
  localparam logic [2:0] RegWindow   = 3'd7;

  // mounting group codes (high nibble of the order register) and sub codes (low nibble)
  localparam logic [3:0] Grp1 = 4'h1;
  localparam logic [3:0] Grp2 = 4'h2;
  localparam logic [3:0] Grp3 = 4'h3;
  localparam logic [3:0] Grp4 = 4'h4;
  localparam logic [3:0] Grp5 = 4'h5;
  localparam logic [3:0] Grp6 = 4'h6;
  localparam logic [3:0] SubA = 4'h1;
  localparam logic [3:0] SubB = 4'h2;

  typedef struct packed {
    logic bad_order;
    logic trip;
  } trip_res_t;

  // below the pivot the negative limit applies, else the positive one
  function automatic logic axis_trips(input logic signed [16:0] d,
                                      input logic [31:0] lim,
                                      input logic signed [16:0] pivot);
    logic signed [16:0] pos_lim;
    logic signed [16:0] neg_lim;
    pos_lim = {lim[31], lim[31:16]};
    neg_lim = {lim[15], lim[15:0]};
    return (d < pivot) ? (d <= neg_lim) : (d >= pos_lim);
  endfunction

endpackage

/* rtl/core/gewt_ram.sv */
// ----------------------------------------------------------------------------
// gewt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gewt_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gewt_trip.sv */
// ----------------------------------------------------------------------------
// gewt_trip
// axis mapping, reference subtraction and limit compares
// ----------------------------------------------------------------------------
module gewt_trip #(
  parameter int COUNTS_PER_G = 37
) (
  input  logic [15:0]         raw_x_i,
  input  logic [15:0]         raw_y_i,
  input  logic [15:0]         raw_z_i,
  input  logic [15:0]         ref_x_i,
  input  logic [15:0]         ref_y_i,
  input  logic [15:0]         ref_z_i,
  input  logic [7:0]          axis_order_i,
  input  logic [31:0]         fb_limits_i,
  input  logic [31:0]         lr_limits_i,
  input  logic [31:0]         ud_limits_i,
  output gewt_pkg::trip_res_t res_o
);
  import gewt_pkg::*;

  localparam logic signed [16:0] UdPivot = 17'(COUNTS_PER_G);

  logic signed [16:0] dx, dy, dz, fb, lr, ud;
  logic [3:0] hi, lo;
  logic first;

  assign dx = $signed({1'b0, raw_x_i}) - $signed({1'b0, ref_x_i});
  assign dy = $signed({1'b0, raw_y_i}) - $signed({1'b0, ref_y_i});
  assign dz = $signed({1'b0, raw_z_i}) - $signed({1'b0, ref_z_i});
  assign hi = axis_order_i[7:4];
  assign lo = axis_order_i[3:0];
  assign first = (lo == SubA) || (lo == SubB);

  always_comb begin
    fb = dx;
    lr = dy;
    ud = dz;
    res_o.bad_order = 1'b0;
    unique case (hi)
      Grp1, Grp2: begin
        fb = first ? dx : dy;
        lr = first ? dy : dx;
        ud = dz;
      end
      Grp3, Grp4: begin
        fb = first ? dy : dz;
        lr = first ? dz : dy;
        ud = dx;
      end
      Grp5, Grp6: begin
        fb = first ? dx : dz;
        lr = first ? dz : dx;
        ud = dy;
      end
      default: begin
        res_o.bad_order = 1'b1;
      end
    endcase
    res_o.trip = !res_o.bad_order &&
                 (axis_trips(fb, fb_limits_i, 17'sd0) ||
                  axis_trips(lr, lr_limits_i, 17'sd0) ||
                  axis_trips(ud, ud_limits_i, UdPivot));
  end

endmodule

/* rtl/core/gforce_event_window_table_unit.sv */
// ----------------------------------------------------------------------------
// gforce_event_window_table_unit
// g-force trip detection with a sorted table of merged time intervals
// ----------------------------------------------------------------------------
// flow: a quiet or bad-order sample goes from eval straight to the result stage;
// a trip walks the table one entry at a time (up to the used count), then for a
// new interval moves each entry above the insert slot up (read, then write) and
// writes the new interval before the result stage
// one sample at a time; the table ram accesses and the entry walk set the rate
// reset clears the control state and the entry count, sets the config registers to
// defaults; table contents are not cleared, only entries below the count are ever read
module gforce_event_window_table_unit #(
  parameter int TABLE_DEPTH  = 64,
  parameter int COUNTS_PER_G = 37
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // sample input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] event_time_i,
  input  logic [15:0] raw_x_i,
  input  logic [15:0] raw_y_i,
  input  logic [15:0] raw_z_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tripped_o,
  output logic [2:0]  action_o,
  output logic [5:0]  slot_o,
  output logic [31:0] interval_begin_o,
  output logic [31:0] interval_finish_o,
  output logic [6:0]  entries_used_o
);
  import gewt_pkg::*;
  `include "gforce_event_window_table_unit_assert.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_EVAL = 3'd1;  // trip test, start of walk
  localparam logic [2:0] S_WALK = 3'd2;  // one table entry per cycle
  localparam logic [2:0] S_SHRD = 3'd3;  // read entry to move up
  localparam logic [2:0] S_SHWR = 3'd4;  // write it one slot higher
  localparam logic [2:0] S_INS  = 3'd5;  // write the new interval
  localparam logic [2:0] S_FIN  = 3'd6;  // hand result to output register

  // configuration registers
  logic [15:0] ref_x_q, ref_y_q, ref_z_q, win_q;
  logic [7:0]  order_q;
  logic [31:0] fb_lim_q, lr_lim_q, ud_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q  <= 16'd512;
      ref_y_q  <= 16'd512;
      ref_z_q  <= 16'd512;
      order_q  <= 8'h12;
      fb_lim_q <= 32'd2949072;
      lr_lim_q <= 32'd2490331;
      ud_lim_q <= 32'd7339958;
      win_q    <= 16'd60;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRefX:   ref_x_q  <= cfg_wdata_i[15:0];
        RegRefY:   ref_y_q  <= cfg_wdata_i[15:0];
        RegRefZ:   ref_z_q  <= cfg_wdata_i[15:0];
        RegOrder:  order_q  <= cfg_wdata_i[7:0];
        RegFbLim:  fb_lim_q <= cfg_wdata_i;
        RegLrLim:  lr_lim_q <= cfg_wdata_i;
        RegUdLim:  ud_lim_q <= cfg_wdata_i;
        RegWindow: win_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          pos_found_q, pos_found_d;
  logic [CW-1:0] used_q, used_d;
  logic          out_valid_q, out_valid_d;

  // sample and staged result, payload only
  logic [31:0]   t_q, t_d;
  logic [15:0]   rx_q, ry_q, rz_q;
  logic          res_trip_q, res_trip_d;
  logic [2:0]    res_act_q, res_act_d;
  logic [AW-1:0] res_slot_q, res_slot_d;
  logic [31:0]   res_b_q, res_b_d, res_f_q, res_f_d;

  logic          o_trip_q;
  logic [2:0]    o_act_q;
  logic [5:0]    o_slot_q;
  logic [31:0]   o_b_q, o_f_q;
  logic [6:0]    o_used_q;

  // table ram: begin in the upper half, finish in the lower half
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  gewt_ram #(
    .Width (64),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  trip_res_t trip_res;

  gewt_trip #(
    .COUNTS_PER_G (COUNTS_PER_G)
  ) u_trip (
    .raw_x_i      (rx_q),
    .raw_y_i      (ry_q),
    .raw_z_i      (rz_q),
    .ref_x_i      (ref_x_q),
    .ref_y_i      (ref_y_q),
    .ref_z_i      (ref_z_q),
    .axis_order_i (order_q),
    .fb_limits_i  (fb_lim_q),
    .lr_limits_i  (lr_lim_q),
    .ud_limits_i  (ud_lim_q),
    .res_o        (trip_res)
  );

  // compares on the entry just read, widened by one bit so nothing wraps
  logic [31:0] eb, ef;
  logic [32:0] t_w, f_w;
  logic        head_new, m_start, m_cov, m_end, b_above, last_entry, full;
  logic [AW-1:0] pos_now;

  assign eb         = ram_rdata[63:32];
  assign ef         = ram_rdata[31:0];
  assign t_w        = {1'b0, t_q} + {17'd0, win_q};
  assign f_w        = {1'b0, ef} + {17'd0, win_q};
  assign head_new   = (idx_q == '0) && (t_w < {1'b0, eb});
  assign m_start    = (t_w >= {1'b0, eb}) && (t_q < eb);
  assign m_cov      = (t_q >= eb) && (t_q <= ef);
  assign m_end      = (t_q > ef) && ({1'b0, t_q} <= f_w);
  assign b_above    = eb > t_q;
  assign last_entry = (CW'(idx_q) == (used_q - CW'(1)));
  assign full       = (used_q == CW'(TABLE_DEPTH));
  // insert position once the walk is over without a match
  assign pos_now    = pos_found_q ? pos_q : (b_above ? idx_q : AW'(used_q));

  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    t_d         = t_q;
    res_trip_d  = res_trip_q;
    res_act_d   = res_act_q;
    res_slot_d  = res_slot_q;
    res_b_d     = res_b_q;
    res_f_d     = res_f_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {t_q, t_q};
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d     = event_time_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_slot_d  = '0;
        res_b_d     = '0;
        res_f_d     = '0;
        idx_d       = '0;
        pos_d       = '0;
        pos_found_d = 1'b0;
        res_trip_d  = trip_res.trip;
        if (trip_res.bad_order) begin
          res_act_d = ActBadOrder;
          state_d   = S_FIN;
        end else if (!trip_res.trip) begin
          res_act_d = ActQuiet;
          state_d   = S_FIN;
        end else if (used_q == '0) begin
          state_d = S_INS;
        end else begin
          // fetch entry 0
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        res_slot_d = idx_q;
        if (!head_new && m_start) begin
          ram_we    = 1'b1;
          ram_wdata = {t_q, ef};
          res_act_d = ActStartExt;
          res_b_d   = t_q;
          res_f_d   = ef;
          state_d   = S_FIN;
        end else if (!head_new && m_cov) begin
          res_act_d = ActCovered;
          res_b_d   = eb;
          res_f_d   = ef;
          state_d   = S_FIN;
        end else if (!head_new && m_end) begin
          ram_we    = 1'b1;
          ram_wdata = {eb, t_q};
          res_act_d = ActEndExt;
          res_b_d   = eb;
          res_f_d   = t_q;
          state_d   = S_FIN;
        end else if (head_new || last_entry) begin
          // no match anywhere: insert or drop
          pos_d = head_new ? '0 : pos_now;
          if (full) begin
            res_act_d  = ActFull;
            res_slot_d = '0;
            res_b_d    = '0;
            res_f_d    = '0;
            state_d    = S_FIN;
          end else if (CW'(head_new ? '0 : pos_now) < used_q) begin
            idx_d   = AW'(used_q - CW'(1));
            state_d = S_SHRD;
          end else begin
            state_d = S_INS;
          end
        end else begin
          if (b_above && !pos_found_q) begin
            pos_found_d = 1'b1;
            pos_d       = idx_q;
          end
          idx_d     = idx_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
        end
      end
      S_SHRD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = S_SHWR;
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        ram_wdata = ram_rdata;
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          idx_d   = idx_q - AW'(1);
          state_d = S_SHRD;
        end
      end
      S_INS: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_q;
        ram_wdata  = {t_q, t_q};
        used_d     = used_q + CW'(1);
        res_act_d  = ActNew;
        res_slot_d = pos_q;
        res_b_d    = t_q;
        res_f_d    = t_q;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pos_q       <= '0;
      pos_found_q <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      pos_found_q <= pos_found_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    res_trip_q <= res_trip_d;
    res_act_q  <= res_act_d;
    res_slot_q <= res_slot_d;
    res_b_q    <= res_b_d;
    res_f_q    <= res_f_d;
    if (state_q == S_IDLE && in_valid_i) begin
      rx_q <= raw_x_i;
      ry_q <= raw_y_i;
      rz_q <= raw_z_i;
    end
    // output register loads on the result transfer into it
    if (state_q == S_FIN && out_free) begin
      o_trip_q <= res_trip_q;
      o_act_q  <= res_act_q;
      o_slot_q <= 6'(res_slot_q);
      o_b_q    <= res_b_q;
      o_f_q    <= res_f_q;
      o_used_q <= 7'(used_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tripped_o         = o_trip_q;
  assign action_o          = o_act_q;
  assign slot_o            = o_slot_q;
  assign interval_begin_o  = o_b_q;
  assign interval_finish_o = o_f_q;
  assign entries_used_o    = o_used_q;

  `GEWT_ASSERT(a_used_max, clk_i, rst_ni, used_q <= CW'(TABLE_DEPTH))
  `GEWT_ASSERT(a_acc_eval, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_EVAL))
  `GEWT_ASSERT_NEVER(a_no_wr_idle, clk_i, rst_ni, ram_we && (state_q == S_IDLE || state_q == S_FIN))

endmodule

/* tb/sv/tb_gforce_event_window_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_gforce_event_window_table_unit
// self-checking bench: directed rows, then random config phases, each sample
// transfer run through a local model of the trip test and the interval table
// ----------------------------------------------------------------------------
module tb_gforce_event_window_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gewt_pkg::*;

  localparam int Depth     = 64;
  localparam int CountsG   = 37;
  localparam int DrainWait = 300;     // beyond worst walk plus shift of a full table
  localparam int IdleLimit = 20000;   // cycles without any transfer

  typedef struct packed {
    logic        trip;
    logic [2:0]  act;
    logic [5:0]  slot;
    logic [31:0] ibeg;
    logic [31:0] ifin;
    logic [6:0]  used;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [31:0] t;
    logic [15:0] x, y, z;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] event_time_i = '0;
  logic [15:0] raw_x_i = '0, raw_y_i = '0, raw_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        tripped_o;
  logic [2:0]  action_o;
  logic [5:0]  slot_o;
  logic [31:0] interval_begin_o, interval_finish_o;
  logic [6:0]  entries_used_o;

  gforce_event_window_table_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the registers and the interval table
  logic [15:0] m_ref [3];
  logic [7:0]  m_order;
  logic [31:0] m_lim [3];   // fb, lr, ud
  logic [15:0] m_window;
  logic [31:0] tbl_begin [Depth];
  logic [31:0] tbl_finish [Depth];
  int          tbl_used;

  result_t pending_results [$];
  int      n_errors = 0;
  int      idle_cycles = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void model_write(input logic [2:0] idx, input logic [31:0] d);
    case (idx)
      RegRefX:   m_ref[0] = d[15:0];
      RegRefY:   m_ref[1] = d[15:0];
      RegRefZ:   m_ref[2] = d[15:0];
      RegOrder:  m_order = d[7:0];
      RegFbLim:  m_lim[0] = d;
      RegLrLim:  m_lim[1] = d;
      RegUdLim:  m_lim[2] = d;
      RegWindow: m_window = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic bit crosses(input int d, input logic [31:0] lim, input int pivot);
    int p, n;
    p = $signed(lim[31:16]);
    n = $signed(lim[15:0]);
    return (d < pivot) ? (d <= n) : (d >= p);
  endfunction

  // trip test plus table merge for one sample, updates the local table
  function automatic result_t table_merge(input logic [31:0] t, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] z);
    result_t r;
    int dx, dy, dz, fb, lr, ud, pos;
    logic [3:0] hi, lo;
    bit first;
    longint tt, w, b, f;
    r = '0;
    dx = int'(x) - int'(m_ref[0]);
    dy = int'(y) - int'(m_ref[1]);
    dz = int'(z) - int'(m_ref[2]);
    hi = m_order[7:4];
    lo = m_order[3:0];
    first = (lo == SubA) || (lo == SubB);
    if (hi == Grp1 || hi == Grp2) begin
      fb = first ? dx : dy; lr = first ? dy : dx; ud = dz;
    end else if (hi == Grp3 || hi == Grp4) begin
      fb = first ? dy : dz; lr = first ? dz : dy; ud = dx;
    end else if (hi == Grp5 || hi == Grp6) begin
      fb = first ? dx : dz; lr = first ? dz : dx; ud = dy;
    end else begin
      r.act = ActBadOrder;
      r.used = tbl_used[6:0];
      return r;
    end
    r.used = tbl_used[6:0];
    if (!(crosses(fb, m_lim[0], 0) || crosses(lr, m_lim[1], 0) ||
          crosses(ud, m_lim[2], CountsG))) begin
      r.act = ActQuiet;
      return r;
    end
    r.trip = 1'b1;
    tt = longint'(t);
    w = longint'(m_window);
    if (tbl_used != 0 && !(tt < longint'(tbl_begin[0]) - w)) begin
      for (int i = 0; i < tbl_used; i++) begin
        b = longint'(tbl_begin[i]);
        f = longint'(tbl_finish[i]);
        if (tt >= b - w && tt < b) begin
          tbl_begin[i] = t;
          r.act = ActStartExt;
        end else if (tt >= b && tt <= f) begin
          r.act = ActCovered;
        end else if (tt > f && tt <= f + w) begin
          tbl_finish[i] = t;
          r.act = ActEndExt;
        end
        if (r.act != ActQuiet) begin
          r.slot = i[5:0];
          r.ibeg = tbl_begin[i];
          r.ifin = tbl_finish[i];
          return r;
        end
      end
    end
    if (tbl_used >= Depth) begin
      r.act = ActFull;
      return r;
    end
    pos = tbl_used;
    for (int i = 0; i < tbl_used; i++)
      if (tbl_begin[i] > t) begin
        pos = i;
        break;
      end
    for (int i = tbl_used; i > pos; i--) begin
      tbl_begin[i] = tbl_begin[i-1];
      tbl_finish[i] = tbl_finish[i-1];
    end
    tbl_begin[pos] = t;
    tbl_finish[pos] = t;
    tbl_used++;
    r.act = ActNew;
    r.slot = pos[5:0];
    r.ibeg = t;
    r.ifin = t;
    r.used = tbl_used[6:0];
    return r;
  endfunction

  // register write, only while nothing is in flight
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_write(idx, d);
  endtask

  // one sample transfer with a random gap in front of it
  task automatic send_sample(input logic [31:0] t, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input bit typed, input result_t typed_res);
    int gap;
    result_t r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7, 8:    gap = $urandom_range(1, 4);
      default:       gap = $urandom_range(20, 150);
    endcase
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    event_time_i <= t;
    raw_x_i <= x;
    raw_y_i <= y;
    raw_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    r = table_merge(t, x, y, z);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // result side: compare every transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (tripped_o !== e.trip)
          report($sformatf("tripped %0b exp %0b", tripped_o, e.trip));
        if (action_o !== e.act)
          report($sformatf("action %0d exp %0d", action_o, e.act));
        if (slot_o !== e.slot)
          report($sformatf("slot %0d exp %0d", slot_o, e.slot));
        if (interval_begin_o !== e.ibeg)
          report($sformatf("begin %0h exp %0h", interval_begin_o, e.ibeg));
        if (interval_finish_o !== e.ifin)
          report($sformatf("finish %0h exp %0h", interval_finish_o, e.ifin));
        if (entries_used_o !== e.used)
          report($sformatf("used %0d exp %0d", entries_used_o, e.used));
      end
    end
  end

  // watchdog on transfers of either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls: runs of ready, short stalls, the odd long one
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      out_ready_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 200)) @(posedge clk_i);
      else repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  end

  function automatic row_t smp(input logic [31:0] t, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z);
    row_t r;
    r = '{default: '0};
    r.t = t; r.x = x; r.y = y; r.z = z;
    return r;
  endfunction

  function automatic row_t smp_exp(input logic [31:0] t, input logic [15:0] x,
                                   input logic [15:0] y, input logic [15:0] z,
                                   input result_t e);
    row_t r;
    r = smp(t, x, y, z);
    r.typed = 1'b1;
    r.res = e;
    return r;
  endfunction

  function automatic row_t wr(input logic [2:0] idx, input logic [31:0] d);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.idx = idx; r.data = d;
    return r;
  endfunction

  // raw axis word around the reference, sometimes at the rails
  function automatic logic [15:0] pick_axis(input logic [15:0] ref_cnt);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'(ref_cnt) + $urandom_range(0, 300) - 150;
      6, 7:             v = $urandom_range(0, 65535);
      8:                v = $urandom_range(0, 1) ? 65535 : 0;
      default:          v = ref_cnt;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick_limits();
    logic [15:0] p, n;
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return 32'h7FFF_8000;   // widest 16-bit limits; a 17-bit delta can still reach them
      2:       return 32'h0000_0000;
      default: begin
        p = 16'($urandom_range(5, 150));
        n = 16'(-$urandom_range(5, 150));
        return {p, n};
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_order(input bit bad);
    logic [3:0] hi;
    if (bad) hi = $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(7, 15));
    else     hi = 4'($urandom_range(1, 6));
    return {hi, 4'($urandom_range(0, 15))};
  endfunction

  row_t    directed [$];
  result_t e;
  int      n_phases;
  logic [31:0] t_base, t_spread;
  logic [15:0] win;

  initial begin
    m_ref = '{16'd512, 16'd512, 16'd512};
    m_order = 8'h12;
    m_lim = '{32'd2949072, 32'd2490331, 32'd7339958};
    m_window = 16'd60;
    tbl_used = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: fb=x +44/-48, lr=y +37/-37, ud=z +111/-74, window 60
    e = '0;
    directed.push_back(smp_exp(32'd1000, 16'd512, 16'd512, 16'd512, e));    // quiet
    e = '{1'b1, ActNew, 6'd0, 32'd1000, 32'd1000, 7'd1};
    directed.push_back(smp_exp(32'd1000, 16'd556, 16'd512, 16'd512, e));    // fb positive edge
    directed.push_back(smp(32'd1030, 16'd463, 16'd512, 16'd512));          // end extended
    directed.push_back(smp(32'd950, 16'd512, 16'd549, 16'd512));           // start extended
    directed.push_back(smp(32'd1000, 16'd512, 16'd475, 16'd512));          // covered
    directed.push_back(smp(32'd5000, 16'd512, 16'd512, 16'd623));          // ud positive
    directed.push_back(smp(32'd5000, 16'd512, 16'd512, 16'd548));          // ud just under pivot
    directed.push_back(smp(32'd3000, 16'd512, 16'd512, 16'd438));          // sorted insert mid
    directed.push_back(smp(32'd0, 16'd0, 16'd512, 16'd512));               // head, time zero
    directed.push_back(smp(32'hFFFF_FFFF, 16'hFFFF, 16'd512, 16'd512));   // tail, max time
    directed.push_back(smp(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(smp(32'hFFFF_FFC4, 16'd0, 16'd0, 16'd0));          // start ext at top
    directed.push_back(wr(RegOrder, 32'h00));
    e = '0; e.act = ActBadOrder; e.used = 7'd5;
    directed.push_back(smp_exp(32'd7000, 16'hFFFF, 16'd0, 16'hFFFF, e));
    directed.push_back(wr(RegOrder, 32'hF2));
    directed.push_back(smp(32'd7000, 16'd0, 16'hFFFF, 16'd0));
    directed.push_back(wr(RegOrder, 32'h31));
    directed.push_back(smp(32'd9000, 16'd512, 16'd600, 16'd512));
    directed.push_back(wr(RegOrder, 32'h4F));
    directed.push_back(smp(32'd9040, 16'd512, 16'd512, 16'd400));
    directed.push_back(wr(RegOrder, 32'h52));
    directed.push_back(smp(32'd12000, 16'd512, 16'd700, 16'd512));
    directed.push_back(wr(RegOrder, 32'h6C));
    directed.push_back(smp(32'd12000, 16'd512, 16'd512, 16'd300));
    directed.push_back(wr(RegOrder, 32'h27));
    directed.push_back(smp(32'd20000, 16'd512, 16'd470, 16'd512));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) cfg_write(directed[i].idx, directed[i].data);
      else send_sample(directed[i].t, directed[i].x, directed[i].y, directed[i].z,
                       directed[i].typed, directed[i].res);
    end

    // random phases; phase 6 fills the table with zero window and wide times
    n_phases = 8;
    for (int ph = 0; ph < n_phases; ph++) begin
      cfg_write(RegRefX, ph == 1 ? 32'h0 : (ph == 2 ? 32'hFFFF : $urandom_range(0, 65535)));
      cfg_write(RegRefY, ph == 2 ? 32'h0 : $urandom_range(0, 65535));
      cfg_write(RegRefZ, ph == 1 ? 32'hFFFF : $urandom_range(0, 65535));
      cfg_write(RegOrder, pick_order(ph == 3));
      cfg_write(RegFbLim, pick_limits());
      cfg_write(RegLrLim, pick_limits());
      cfg_write(RegUdLim, pick_limits());
      case (ph)
        6:       win = 16'd0;
        4:       win = 16'hFFFF;
        default: win = 16'($urandom_range(0, 200));
      endcase
      cfg_write(RegWindow, {16'h0, win});
      case (ph)
        0:       t_base = 32'd0;
        5:       t_base = 32'hFFFF_0000;
        default: t_base = $urandom_range(0, 32'hF000_0000);
      endcase
      t_spread = (ph == 6) ? 32'd2_000_000 : $urandom_range(500, 5000);
      for (int k = 0; k < 135; k++) begin
        logic [31:0] t;
        // sender holds off once per phase until the result side is empty
        if (k == 60) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        t = ($urandom_range(0, 19) == 0) ? $urandom
                                         : t_base + $urandom_range(0, t_spread);
        send_sample(t, pick_axis(m_ref[0]), pick_axis(m_ref[1]), pick_axis(m_ref[2]),
                    1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
